// ----- src/cbc_pkg.sv -----
// shared types and constants for the circle and box collision pipeline
`timescale 1ns / 1ps

package cbc_pkg;

   // coordinate width of the position fields
   localparam int COORD_BITS = 16;

   localparam int CW     = COORD_BITS;
   localparam int SIZE_W = 14;
   // wide enough for 2*pos + 2*r - 2*pos - size in half-pixels
   localparam int OW     = ((CW > SIZE_W + 1) ? CW : (SIZE_W + 1)) + 4;
   // doubled radius, half-pixels
   localparam int R2_W   = SIZE_W + 1;
   localparam int SQ_W   = 2 * R2_W;
   // signed vector component, magnitude bounded by the doubled radius
   localparam int VEC_W  = R2_W + 2;
   localparam int DIFF_W = 18;
   localparam int SIDE_W = 3;

   localparam logic SHAPE_BOX    = 1'b0;
   localparam logic SHAPE_CIRCLE = 1'b1;

   localparam logic [SIDE_W-1:0] SIDE_UP    = 3'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 3'd1;
   localparam logic [SIDE_W-1:0] SIDE_DOWN  = 3'd2;
   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 3'd3;
   localparam logic [SIDE_W-1:0] SIDE_NONE  = 3'd4;

   typedef struct packed {
      logic              shape_a;
      logic              shape_b;
      logic [CW-1:0]     a_pos_x;
      logic [CW-1:0]     a_pos_y;
      logic [SIZE_W-1:0] a_width;
      logic [SIZE_W-1:0] a_height;
      logic [SIZE_W-1:0] a_radius;
      logic [CW-1:0]     b_pos_x;
      logic [CW-1:0]     b_pos_y;
      logic [SIZE_W-1:0] b_width;
      logic [SIZE_W-1:0] b_height;
      logic [SIZE_W-1:0] b_radius;
   } req_type;

   // after the offset stage
   typedef struct packed {
      logic              mixed;
      logic              box_hit;
      logic              second;
      logic [OW-1:0]     ox;
      logic [OW-1:0]     oy;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic [SIZE_W-1:0] r;
   } s1_type;

   // after the clamp stage
   typedef struct packed {
      logic            mixed;
      logic            box_hit;
      logic            second;
      logic [OW-1:0]   mag_x;
      logic [OW-1:0]   mag_y;
      logic            neg_x;
      logic            neg_y;
      logic [R2_W-1:0] r2;
      logic [SQ_W-1:0] r2sq;
   } s2_type;

   // after the square stage
   typedef struct packed {
      logic             mixed;
      logic             box_hit;
      logic             second;
      logic             in_range;
      logic [VEC_W-1:0] dx;
      logic [VEC_W-1:0] dy;
      logic [SQ_W-1:0]  sq_x;
      logic [SQ_W-1:0]  sq_y;
      logic [SQ_W-1:0]  r2sq;
   } s3_type;

endpackage

// ----- src/circle_box_collision_test.sv -----
// top level of the circle and box collision test pipeline
`timescale 1ns / 1ps

//  channel   direction   handshake             payload
//  req_      in          req_valid, req_stall  two objects: shape, position, size, radius
//  rsp_      out         rsp_valid, rsp_stall  hit, role order, side, difference vector
//
//  four register stages: offsets, clamp, squares, compare and side pick
//  a pair taken in passes the offset, clamp, square and output registers in that order;
//  one pair per cycle while rsp_stall does not hold the output
//  the output register is the last stage; a stall on rsp_ backs up stage by stage,
//  so bubbles are squeezed out before req_stall is raised
//  reset clears only the stage valid bits; payload registers are not reset

module circle_box_collision_test (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_shape_a,
   input  logic                                    req_shape_b,
   input  logic signed [cbc_pkg::COORD_BITS-1:0]   req_a_pos_x,
   input  logic signed [cbc_pkg::COORD_BITS-1:0]   req_a_pos_y,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_a_width,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_a_height,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_a_radius,
   input  logic signed [cbc_pkg::COORD_BITS-1:0]   req_b_pos_x,
   input  logic signed [cbc_pkg::COORD_BITS-1:0]   req_b_pos_y,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_b_width,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_b_height,
   input  logic        [cbc_pkg::SIZE_W-1:0]       req_b_radius,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_hit,
   output logic                                    rsp_circle_is_second,
   output logic                                    rsp_has_vector,
   output logic        [cbc_pkg::SIDE_W-1:0]       rsp_side,
   output logic signed [cbc_pkg::DIFF_W-1:0]       rsp_diff_x,
   output logic signed [cbc_pkg::DIFF_W-1:0]       rsp_diff_y
);
   import cbc_pkg::*;

   // side choice: the largest of up, right, down, left above zero, a tie goes to the earlier one
   function automatic logic [SIDE_W-1:0] pick_side(input logic [VEC_W-1:0] dx,
                                                    input logic [VEC_W-1:0] dy);
      logic signed [VEC_W:0]  c_up, c_right, c_down, c_left, best;
      logic [SIDE_W-1:0]      pick;
      c_up    = (VEC_W+1)'(signed'(dy));
      c_right = (VEC_W+1)'(signed'(dx));
      c_down  = -c_up;
      c_left  = -c_right;
      best    = '0;
      pick    = SIDE_NONE;
      if (c_up > best) begin
         best = c_up;
         pick = SIDE_UP;
      end
      if (c_right > best) begin
         best = c_right;
         pick = SIDE_RIGHT;
      end
      if (c_down > best) begin
         best = c_down;
         pick = SIDE_DOWN;
      end
      if (c_left > best) begin
         pick = SIDE_LEFT;
      end
      return pick;
   endfunction

   req_type req;
   s1_type  s1_ff;
   s2_type  s2_ff;
   s3_type  s3_ff;

   // stage valid bits
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   // stage load enables, a stage moves when empty or when the next one moves
   logic en1, en2, en3, en4;

   // output stage
   logic [SQ_W:0]             dist_sq;
   logic                      vec_hit;
   logic                      hit_ff, hit_in;
   logic                      second_ff, second_in;
   logic                      hasv_ff, hasv_in;
   logic [SIDE_W-1:0]         side_ff, side_in;
   logic [DIFF_W-1:0]         diff_x_ff, diff_x_in;
   logic [DIFF_W-1:0]         diff_y_ff, diff_y_in;

   assign req = '{shape_a:  req_shape_a,  shape_b:  req_shape_b,
                  a_pos_x:  req_a_pos_x,  a_pos_y:  req_a_pos_y,
                  a_width:  req_a_width,  a_height: req_a_height,
                  a_radius: req_a_radius,
                  b_pos_x:  req_b_pos_x,  b_pos_y:  req_b_pos_y,
                  b_width:  req_b_width,  b_height: req_b_height,
                  b_radius: req_b_radius};

   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff     : v2_ff;
   assign v3_in = en3 ? v2_ff     : v3_ff;
   assign v4_in = en4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   cbc_offset u_offset (
      .clock  (clock),
      .enable (en1),
      .req    (req),
      .s1_ff  (s1_ff)
   );

   cbc_clamp u_clamp (
      .clock  (clock),
      .enable (en2),
      .s1     (s1_ff),
      .s2_ff  (s2_ff)
   );

   cbc_square u_square (
      .clock  (clock),
      .enable (en3),
      .s2     (s2_ff),
      .s3_ff  (s3_ff)
   );

   // squared distance against squared doubled radius, then side pick
   always_comb begin
      dist_sq  = (SQ_W+1)'(s3_ff.sq_x) + (SQ_W+1)'(s3_ff.sq_y);
      vec_hit  = s3_ff.mixed && s3_ff.in_range && (dist_sq <= (SQ_W+1)'(s3_ff.r2sq));

      hit_in    = s3_ff.box_hit || vec_hit;
      second_in = s3_ff.second;
      hasv_in   = vec_hit;
      side_in   = vec_hit ? pick_side(s3_ff.dx, s3_ff.dy) : SIDE_NONE;
      diff_x_in = vec_hit ? DIFF_W'(signed'(s3_ff.dx)) : '0;
      diff_y_in = vec_hit ? DIFF_W'(signed'(s3_ff.dy)) : '0;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         hit_ff    <= hit_in;
         second_ff <= second_in;
         hasv_ff   <= hasv_in;
         side_ff   <= side_in;
         diff_x_ff <= diff_x_in;
         diff_y_ff <= diff_y_in;
      end
   end

   assign rsp_valid            = v4_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_circle_is_second = second_ff;
   assign rsp_has_vector       = hasv_ff;
   assign rsp_side             = side_ff;
   assign rsp_diff_x           = signed'(diff_x_ff);
   assign rsp_diff_y           = signed'(diff_y_ff);

   // a vector result is always a hit
   a_vector_is_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_vector |-> rsp_hit)
      else $error("vector result without hit");

   // no vector means no side and a zero difference
   a_plain_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_vector |->
         rsp_side == SIDE_NONE && rsp_diff_x == '0 && rsp_diff_y == '0)
      else $error("side or difference set without a vector");

   // side is none exactly when the vector is zero
   a_side_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_vector |->
         ((rsp_side == SIDE_NONE) == (rsp_diff_x == '0 && rsp_diff_y == '0)))
      else $error("side does not match the difference vector");

   // a held stage keeps its item while the next one cannot take it
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      v3_ff && !en4 |=> v3_ff && v4_ff)
      else $error("stage three dropped an item under stall");

   // input stalled only when the whole pipe is full
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall)
      else $error("input stalled with a bubble in the pipe");

endmodule

// ----- src/cbc_offset.sv -----
// first stage: role swap, centre offsets and box against box overlap
`timescale 1ns / 1ps

module cbc_offset (
   input  logic            clock,
   input  logic            enable,
   input  cbc_pkg::req_type req,
   output cbc_pkg::s1_type  s1_ff
);
   import cbc_pkg::*;

   logic signed [OW-1:0] ax_e, ay_e, bx_e, by_e;
   logic signed [OW-1:0] aw_e, ah_e, bw_e, bh_e;
   logic signed [OW-1:0] cx_e, cy_e, r_e, px_e, py_e, w_e, h_e;
   logic                 circ_first;
   logic                 over_x, over_y;
   s1_type               s1_in;

   always_comb begin
      ax_e = OW'(signed'(req.a_pos_x));
      ay_e = OW'(signed'(req.a_pos_y));
      bx_e = OW'(signed'(req.b_pos_x));
      by_e = OW'(signed'(req.b_pos_y));
      aw_e = signed'(OW'(req.a_width));
      ah_e = signed'(OW'(req.a_height));
      bw_e = signed'(OW'(req.b_width));
      bh_e = signed'(OW'(req.b_height));

      circ_first = (req.shape_a == SHAPE_CIRCLE);
      cx_e = circ_first ? ax_e : bx_e;
      cy_e = circ_first ? ay_e : by_e;
      px_e = circ_first ? bx_e : ax_e;
      py_e = circ_first ? by_e : ay_e;
      w_e  = circ_first ? bw_e : aw_e;
      h_e  = circ_first ? bh_e : ah_e;
      r_e  = signed'(OW'(circ_first ? req.a_radius : req.b_radius));

      // inclusive overlap per axis
      over_x = (ax_e + aw_e >= bx_e) && (bx_e + bw_e >= ax_e);
      over_y = (ay_e + ah_e >= by_e) && (by_e + bh_e >= ay_e);

      s1_in.mixed   = (req.shape_a != req.shape_b);
      s1_in.second  = s1_in.mixed && !circ_first;
      s1_in.box_hit = (req.shape_a == SHAPE_BOX) && (req.shape_b == SHAPE_BOX)
                      && over_x && over_y;
      // circle centre minus box centre, half-pixels
      s1_in.ox = ((cx_e + r_e) <<< 1) - ((px_e <<< 1) + w_e);
      s1_in.oy = ((cy_e + r_e) <<< 1) - ((py_e <<< 1) + h_e);
      s1_in.w  = circ_first ? req.b_width  : req.a_width;
      s1_in.h  = circ_first ? req.b_height : req.a_height;
      s1_in.r  = circ_first ? req.a_radius : req.b_radius;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff <= s1_in;
      end
   end

endmodule

// ----- src/cbc_clamp.sv -----
// second stage: clamp to the half-extents, vector magnitude and sign
`timescale 1ns / 1ps

module cbc_clamp (
   input  logic            clock,
   input  logic            enable,
   input  cbc_pkg::s1_type s1,
   output cbc_pkg::s2_type s2_ff
);
   import cbc_pkg::*;

   logic signed [OW-1:0] ox, oy, w_e, h_e;
   logic                 lo_x, hi_x, lo_y, hi_y;
   logic [R2_W-1:0]      r2;
   s2_type               s2_in;

   always_comb begin
      ox  = signed'(s1.ox);
      oy  = signed'(s1.oy);
      w_e = signed'(OW'(s1.w));
      h_e = signed'(OW'(s1.h));
      lo_x = ox < -w_e;
      hi_x = ox > w_e;
      lo_y = oy < -h_e;
      hi_y = oy > h_e;
      r2   = {s1.r, 1'b0};

      s2_in.mixed   = s1.mixed;
      s2_in.box_hit = s1.box_hit;
      s2_in.second  = s1.second;
      // clamped point minus offset: positive below the box, negative above it
      s2_in.mag_x = lo_x ? (-w_e - ox) : (hi_x ? (ox - w_e) : '0);
      s2_in.mag_y = lo_y ? (-h_e - oy) : (hi_y ? (oy - h_e) : '0);
      s2_in.neg_x = hi_x;
      s2_in.neg_y = hi_y;
      s2_in.r2    = r2;
      s2_in.r2sq  = SQ_W'(r2) * SQ_W'(r2);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_ff <= s2_in;
      end
   end

endmodule

// ----- src/cbc_square.sv -----
// third stage: range check against the doubled radius and the two squares
`timescale 1ns / 1ps

module cbc_square (
   input  logic            clock,
   input  logic            enable,
   input  cbc_pkg::s2_type s2,
   output cbc_pkg::s3_type s3_ff
);
   import cbc_pkg::*;

   logic [R2_W-1:0] low_x, low_y;
   s3_type          s3_in;

   always_comb begin
      // only the low bits matter once the magnitude is within range
      low_x = s2.mag_x[R2_W-1:0];
      low_y = s2.mag_y[R2_W-1:0];

      s3_in.mixed    = s2.mixed;
      s3_in.box_hit  = s2.box_hit;
      s3_in.second   = s2.second;
      s3_in.in_range = (s2.mag_x <= OW'(s2.r2)) && (s2.mag_y <= OW'(s2.r2));
      s3_in.dx   = s2.neg_x ? -VEC_W'(low_x) : VEC_W'(low_x);
      s3_in.dy   = s2.neg_y ? -VEC_W'(low_y) : VEC_W'(low_y);
      s3_in.sq_x = SQ_W'(low_x) * SQ_W'(low_x);
      s3_in.sq_y = SQ_W'(low_y) * SQ_W'(low_y);
      s3_in.r2sq = s2.r2sq;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_ff <= s3_in;
      end
   end

endmodule
